// ===== hw/rtl/motion_profile_interpolator_defines.svh =====
// Assertion macros for the motion profile interpolator.
`ifndef MOTION_PROFILE_INTERPOLATOR_DEFINES_SVH
`define MOTION_PROFILE_INTERPOLATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only outside reset.
`define MPI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define MPI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPI_ASSERT(label, clk, rst_n, prop, msg)
`define MPI_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/mpi_pkg.sv =====
// Types and constants shared by the motion profile interpolator modules.
package mpi_pkg;

  typedef enum logic [1:0] {
    MODE_ACCEL_DECEL = 2'd0,
    MODE_ACCEL       = 2'd1,
    MODE_DECEL       = 2'd2,
    MODE_LINEAR      = 2'd3
  } mode_t;

  localparam int POS_W  = 8;
  localparam int IDX_W  = 16;
  localparam int SQ_W   = 2 * IDX_W;
  localparam int COEF_W = 10;
  localparam int NUM_W  = 41;
  localparam int DEN_W  = SQ_W + 1;
  localparam int Q_W    = 8;
  localparam int IN_W   = 2 * POS_W + 2 * IDX_W;

  // One item in the divider: num / den, quotient built MSB first.
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   quo;
    logic [POS_W-1:0] start;
    logic             rev;
  } div_t;

endpackage

// ===== hw/rtl/mpi_prep.sv =====
// Front stages: operand clean-up, squares, profile term and numerator.
module mpi_prep (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mpi_pkg::mode_t                 mode,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mpi_pkg::POS_W-1:0]      start_pos,
  input  logic [mpi_pkg::POS_W-1:0]      end_pos,
  input  logic [mpi_pkg::IDX_W-1:0]      idx,
  input  logic [mpi_pkg::IDX_W-1:0]      cnt,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mpi_pkg::div_t                  out_data
);

  typedef struct packed {
    mpi_pkg::mode_t              mode;
    logic [mpi_pkg::IDX_W-1:0]   fn;
    logic [mpi_pkg::IDX_W-1:0]   in;
    logic [mpi_pkg::IDX_W-1:0]   rest;
    logic [mpi_pkg::POS_W-1:0]   span;
    logic [mpi_pkg::POS_W-1:0]   start;
    logic                        rev;
    logic                        lt;
    logic                        eq;
  } s1_t;

  typedef struct packed {
    mpi_pkg::mode_t              mode;
    logic [mpi_pkg::SQ_W-1:0]    ff;
    logic [mpi_pkg::SQ_W-1:0]    prod;
    logic [mpi_pkg::POS_W-1:0]   span;
    logic [mpi_pkg::POS_W-1:0]   start;
    logic                        rev;
    logic                        lt;
    logic                        eq;
  } s2_t;

  typedef struct packed {
    logic [mpi_pkg::SQ_W-1:0]    term;
    logic [mpi_pkg::COEF_W-1:0]  coef;
    logic [mpi_pkg::SQ_W-1:0]    addend;
    logic [mpi_pkg::SQ_W-1:0]    ff;
    logic [mpi_pkg::POS_W-1:0]   start;
    logic                        rev;
  } s3_t;

  logic  v1_r, v2_r, v3_r, v4_r;
  logic  r1, r2, r3, r4;
  s1_t   s1_r, s1_nxt;
  s2_t   s2_r, s2_nxt;
  s3_t   s3_r, s3_nxt;
  mpi_pkg::div_t s4_r, s4_nxt;

  logic [mpi_pkg::IDX_W-1:0]   mul_a, mul_b;
  logic [mpi_pkg::POS_W-2:0]   half;
  logic [mpi_pkg::NUM_W-1:0]   num_full;

  assign r4       = !v4_r || out_ready;
  assign r3       = !v3_r || r4;
  assign r2       = !v2_r || r3;
  assign r1       = !v1_r || r2;
  assign in_ready = r1;

  // Stage 1: zero count reads as one, index saturates at the count.
  always_comb begin
    s1_nxt.mode  = mode;
    s1_nxt.fn    = (cnt == '0) ? mpi_pkg::IDX_W'(1) : cnt;
    s1_nxt.in    = (idx > s1_nxt.fn) ? s1_nxt.fn : idx;
    s1_nxt.rest  = s1_nxt.fn - s1_nxt.in;
    s1_nxt.rev   = start_pos > end_pos;
    s1_nxt.span  = s1_nxt.rev ? (start_pos - end_pos) : (end_pos - start_pos);
    s1_nxt.start = start_pos;
    s1_nxt.lt    = {s1_nxt.in, 1'b0} < {1'b0, s1_nxt.fn};
    s1_nxt.eq    = {s1_nxt.in, 1'b0} == {1'b0, s1_nxt.fn};
  end

  // Stage 2: f squared and the mode's product.
  always_comb begin
    case (s1_r.mode)
      mpi_pkg::MODE_ACCEL: begin
        mul_a = s1_r.in;
        mul_b = s1_r.in;
      end
      mpi_pkg::MODE_DECEL: begin
        mul_a = s1_r.rest;
        mul_b = s1_r.rest;
      end
      mpi_pkg::MODE_LINEAR: begin
        mul_a = s1_r.in;
        mul_b = s1_r.fn;
      end
      default: begin
        mul_a = s1_r.lt ? s1_r.in : s1_r.rest;
        mul_b = mul_a;
      end
    endcase
    s2_nxt.mode  = s1_r.mode;
    s2_nxt.ff    = {{mpi_pkg::IDX_W{1'b0}}, s1_r.fn} * {{mpi_pkg::IDX_W{1'b0}}, s1_r.fn};
    s2_nxt.prod  = {{mpi_pkg::IDX_W{1'b0}}, mul_a} * {{mpi_pkg::IDX_W{1'b0}}, mul_b};
    s2_nxt.span  = s1_r.span;
    s2_nxt.start = s1_r.start;
    s2_nxt.rev   = s1_r.rev;
    s2_nxt.lt    = s1_r.lt;
    s2_nxt.eq    = s1_r.eq;
  end

  // Stage 3: numerator = coef * term + addend.
  // Past the midpoint: 4h*(ff - 2*rest^2) + (D odd ? ff : 0).
  always_comb begin
    half          = s2_r.span[mpi_pkg::POS_W-1:1];
    s3_nxt.ff     = s2_r.ff;
    s3_nxt.start  = s2_r.start;
    s3_nxt.rev    = s2_r.rev;
    s3_nxt.addend = '0;
    s3_nxt.term   = s2_r.prod;
    s3_nxt.coef   = {1'b0, s2_r.span, 1'b0};
    case (s2_r.mode)
      mpi_pkg::MODE_DECEL: begin
        s3_nxt.term = s2_r.ff - s2_r.prod;
      end
      mpi_pkg::MODE_ACCEL_DECEL: begin
        if (s2_r.lt) begin
          s3_nxt.coef = {half, 3'b000};
        end else if (s2_r.eq) begin
          s3_nxt.term = s2_r.ff;
          s3_nxt.coef = {2'b00, half, 1'b0};
        end else begin
          s3_nxt.term   = s2_r.ff - {s2_r.prod[mpi_pkg::SQ_W-2:0], 1'b0};
          s3_nxt.coef   = {1'b0, half, 2'b00};
          s3_nxt.addend = s2_r.span[0] ? s2_r.ff : '0;
        end
      end
      default: begin
        s3_nxt.term = s2_r.prod;
      end
    endcase
  end

  // Stage 4: form the numerator and the denominator 2*f*f.
  always_comb begin
    num_full     = {{(mpi_pkg::NUM_W - mpi_pkg::COEF_W){1'b0}}, s3_r.coef}
                 * {{(mpi_pkg::NUM_W - mpi_pkg::SQ_W){1'b0}}, s3_r.term}
                 + {{(mpi_pkg::NUM_W - mpi_pkg::SQ_W){1'b0}}, s3_r.addend};
    s4_nxt.rem   = num_full;
    s4_nxt.den   = {s3_r.ff, 1'b0};
    s4_nxt.quo   = '0;
    s4_nxt.start = s3_r.start;
    s4_nxt.rev   = s3_r.rev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (r1) v1_r <= in_valid;
      if (r2) v2_r <= v1_r;
      if (r3) v3_r <= v2_r;
      if (r4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) s1_r <= s1_nxt;
    if (r2 && v1_r)     s2_r <= s2_nxt;
    if (r3 && v2_r)     s3_r <= s3_nxt;
    if (r4 && v3_r)     s4_r <= s4_nxt;
  end

  assign out_valid = v4_r;
  assign out_data  = s4_r;

endmodule

// ===== hw/rtl/mpi_div_stage.sv =====
// One restoring division stage: settles a single quotient bit.
module mpi_div_stage #(
  parameter int BIT = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mpi_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mpi_pkg::div_t out_data
);

  logic                      valid_r;
  mpi_pkg::div_t             data_r, data_nxt;
  logic [mpi_pkg::NUM_W-1:0] trial;
  logic                      fits;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    trial    = mpi_pkg::NUM_W'(in_data.den) << BIT;
    fits     = in_data.rem >= trial;
    data_nxt = in_data;
    if (fits) begin
      data_nxt.rem      = in_data.rem - trial;
      data_nxt.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== hw/rtl/motion_profile_interpolator.sv =====
// Motion profile interpolator: top level with mode register and output stage.
//
// Input stream in_*: one transaction per move query carrying start and end
// positions, frame index i and frame count f. Output stream out_*: one
// transaction per input with the interpolated position, floored.
// cfg_*: writes the profile mode (0 accel-decel, 1 accelerate, 2 decelerate,
// 3 linear); always ready; write only while no transaction is in flight.
// Pipeline: four front stages (clean-up, squares, profile term, numerator),
// eight restoring divider stages of one quotient bit each, one output stage.
// Throughput is one transaction per cycle while out_tready does not stall;
// the divider chain sets the depth. Each stage has its own valid bit and
// moves when its successor has room, so a stall on out_tready fills empty
// stages first; in_tready falls only when all thirteen stages hold data.
// Nothing is lost or repeated under a stall.
// Reset empties the pipeline and sets the mode to linear.
`include "motion_profile_interpolator_defines.svh"

module motion_profile_interpolator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] start_position, [15:8] end_position, [31:16] frame_index,
  // [47:32] frame_count
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] position
  output logic [7:0]  out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  localparam int STAGES = mpi_pkg::Q_W;

  mpi_pkg::mode_t mode_r;

  logic          dv_valid [STAGES+1];
  logic          dv_ready [STAGES+1];
  mpi_pkg::div_t dv_data  [STAGES+1];

  logic                      out_valid_r;
  logic [mpi_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                      fin_ready;
  logic [mpi_pkg::Q_W-1:0]   ceil_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mpi_pkg::MODE_LINEAR;
    end else if (cfg_valid) begin
      mode_r <= mpi_pkg::mode_t'(cfg_data);
    end
  end

  mpi_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .start_pos (in_tdata[7:0]),
    .end_pos   (in_tdata[15:8]),
    .idx       (in_tdata[31:16]),
    .cnt       (in_tdata[47:32]),
    .out_valid (dv_valid[0]),
    .out_ready (dv_ready[0]),
    .out_data  (dv_data[0])
  );

  for (genvar g = 0; g < STAGES; g++) begin : g_div
    mpi_div_stage #(
      .BIT (STAGES - 1 - g)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv_valid[g]),
      .in_ready  (dv_ready[g]),
      .in_data   (dv_data[g]),
      .out_valid (dv_valid[g+1]),
      .out_ready (dv_ready[g+1]),
      .out_data  (dv_data[g+1])
    );
  end

  // Reverse moves mirror from the end: end + D = start, minus the ceiling.
  assign fin_ready         = !out_valid_r || out_tready;
  assign dv_ready[STAGES]  = fin_ready;
  assign ceil_q            = dv_data[STAGES].quo
                           + mpi_pkg::Q_W'(dv_data[STAGES].rem != '0);
  assign pos_nxt           = dv_data[STAGES].rev ? (dv_data[STAGES].start - ceil_q)
                                                 : (dv_data[STAGES].start
                                                    + dv_data[STAGES].quo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_ready) begin
      out_valid_r <= dv_valid[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && dv_valid[STAGES]) pos_r <= pos_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pos_r;

  `MPI_ASSERT_ALWAYS(a_mode_reset, clk, !rst_n |=> mode_r == mpi_pkg::MODE_LINEAR, "mode not linear after reset")
  `MPI_ASSERT(a_rem_below_den, clk, rst_n, dv_valid[STAGES] |-> dv_data[STAGES].rem < mpi_pkg::NUM_W'(dv_data[STAGES].den), "division left remainder not below divisor")
  `MPI_ASSERT(a_full_only_on_stall, clk, rst_n, !in_tready |-> (out_tvalid && !out_tready), "input blocked without an output stall")

endmodule

// ===== dv/motion_profile_checker.sv =====
// Checker for the motion profile interpolator: tracks the mode, predicts and compares positions.
`timescale 1ns / 1ps

module motion_profile_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  output int          fail_count,
  output logic        drained
);

  typedef struct {
    bit [7:0]       start_pos;
    bit [7:0]       end_pos;
    bit [15:0]      frame_idx;
    bit [15:0]      frame_cnt;
    mpi_pkg::mode_t mode;
    bit [7:0]       position;
  } move_query_t;

  move_query_t    pending_positions[$];
  mpi_pkg::mode_t cur_mode;
  int             fails = 0;
  logic           empty_q = 1'b1;

  assign fail_count = fails;
  assign drained    = empty_q;

  // Exact rational profile over 2*f*f, floored towards the lower position.
  function automatic bit [7:0] eased_position(mpi_pkg::mode_t mode, bit [7:0] s, bit [7:0] e,
                                              bit [15:0] i, bit [15:0] f);
    longint unsigned cnt, idx, span, half, sq, left, lift, den, pos;
    cnt  = (f == 16'd0) ? 64'd1 : 64'(f);
    idx  = (64'(i) > cnt) ? cnt : 64'(i);
    sq   = cnt * cnt;
    left = cnt - idx;
    span = (s > e) ? 64'(s) - 64'(e) : 64'(e) - 64'(s);
    half = span >> 1;
    case (mode)
      mpi_pkg::MODE_ACCEL:  lift = 2 * span * idx * idx;
      mpi_pkg::MODE_DECEL:  lift = 2 * span * (sq - left * left);
      mpi_pkg::MODE_LINEAR: lift = 2 * span * idx * cnt;
      default: begin
        if (2 * idx < cnt)
          lift = 8 * half * idx * idx;
        else if (2 * idx == cnt)
          lift = 2 * half * sq;
        else
          lift = 4 * half * sq + (span & 64'd1) * sq - 8 * half * left * left;
      end
    endcase
    den = 2 * sq;
    // Reverse moves mirror from the end point, so round the lift up.
    if (s > e)
      pos = 64'(e) + span - (lift + den - 1) / den;
    else
      pos = 64'(s) + lift / den;
    return pos[7:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fails++;
  endtask

  always @(posedge clk) begin
    move_query_t q;
    if (!rst_n) begin
      cur_mode = mpi_pkg::MODE_LINEAR;
      pending_positions.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        q.start_pos = in_tdata[7:0];
        q.end_pos   = in_tdata[15:8];
        q.frame_idx = in_tdata[31:16];
        q.frame_cnt = in_tdata[47:32];
        q.mode      = cur_mode;
        q.position  = eased_position(cur_mode, q.start_pos, q.end_pos,
                                     q.frame_idx, q.frame_cnt);
        pending_positions.push_back(q);
      end
      // A mode write takes effect for the transactions after this edge.
      if (cfg_valid && cfg_ready)
        cur_mode = mpi_pkg::mode_t'(cfg_data);
      if (out_tvalid && out_tready) begin
        if (pending_positions.size() == 0) begin
          report_mismatch($sformatf("unexpected result transaction, position %0d",
                                    out_tdata));
        end else begin
          q = pending_positions.pop_front();
          if (out_tdata !== q.position)
            report_mismatch($sformatf(
              "position %0d, want %0d (mode %s s=%0d e=%0d i=%0d f=%0d)",
              out_tdata, q.position, q.mode.name(), q.start_pos, q.end_pos,
              q.frame_idx, q.frame_cnt));
        end
      end
    end
    empty_q <= (pending_positions.size() == 0);
  end

endmodule

// ===== dv/tb_motion_profile_interpolator.sv =====
// Testbench top for the motion profile interpolator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_motion_profile_interpolator;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_data;
  logic        gaps_on;
  int          fail_count;
  logic        drained;
  int          ready_hold = 0;

  motion_profile_interpolator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  motion_profile_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .drained   (drained)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure in random bursts while gaps_on is set.
  always @(posedge clk) begin
    if (ready_hold > 0)
      ready_hold--;
    else if (gaps_on && $urandom_range(0, 5) == 0)
      ready_hold = $urandom_range(1, 5);
    out_tready <= (ready_hold == 0);
  end

  task automatic send_move(input bit [7:0] s, input bit [7:0] e,
                           input bit [15:0] i, input bit [15:0] f);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {f, i, e, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_move();
    bit [7:0]  s, e;
    bit [15:0] i, f;
    s = 8'($urandom);
    e = 8'($urandom);
    case ($urandom_range(0, 9))
      0: e = s;
      1: begin s = 8'd0;   e = 8'd255; end
      2: begin s = 8'd255; e = 8'd0;   end
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: f = 16'($urandom_range(1, 16));
      4, 5:       f = 16'($urandom_range(17, 1000));
      6, 7:       f = 16'($urandom_range(1001, 65535));
      8:          f = 16'd0;
      default:    f = 16'hFFFF;
    endcase
    case ($urandom_range(0, 9))
      0:       i = f >> 1;
      1:       i = f + 16'($urandom_range(0, 3));
      2:       i = 16'($urandom);
      default: i = (f <= 16'd1) ? 16'd0 : 16'($urandom_range(0, f - 1));
    endcase
    send_move(s, e, i, f);
  endtask

  task automatic write_mode(input mpi_pkg::mode_t mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (!drained) @(posedge clk);
  endtask

  task automatic run_directed();
    send_move(8'd0,   8'd255, 16'd0,     16'd1);
    send_move(8'd255, 8'd0,   16'd32767, 16'd65534);  // exact midpoint, odd distance
    send_move(8'd0,   8'd255, 16'd65535, 16'd65535);  // index at count
    send_move(8'd10,  8'd200, 16'd5,     16'd0);      // zero frame count
    send_move(8'd255, 8'd255, 16'd1,     16'd3);      // no distance
    send_move(8'd200, 8'd7,   16'd40000, 16'd100);    // index beyond count
    in_tvalid <= 1'b0;
  endtask

  initial begin
    mpi_pkg::mode_t directed_modes[4];
    directed_modes = '{mpi_pkg::MODE_LINEAR, mpi_pkg::MODE_ACCEL_DECEL,
                       mpi_pkg::MODE_ACCEL, mpi_pkg::MODE_DECEL};
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= mpi_pkg::MODE_LINEAR;
    gaps_on   <= 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first directed pass runs on the mode left by reset.
    for (int m = 0; m < 4; m++) begin
      if (m > 0) begin
        wait_drained();
        write_mode(directed_modes[m]);
      end
      run_directed();
    end

    for (int ph = 0; ph < 10; ph++) begin
      wait_drained();
      write_mode(ph < 4 ? mpi_pkg::mode_t'(ph) : mpi_pkg::mode_t'($urandom_range(0, 3)));
      if (ph == 9)
        gaps_on <= 1'b0;
      repeat (50) send_random_move();
      in_tvalid <= 1'b0;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== motion_profile_interpolator.f =====
+incdir+hw/rtl
hw/rtl/mpi_pkg.sv
hw/rtl/mpi_prep.sv
hw/rtl/mpi_div_stage.sv
hw/rtl/motion_profile_interpolator.sv
dv/motion_profile_checker.sv
dv/tb_motion_profile_interpolator.sv
